>>> rtl/core/opst_pkg.sv
// opst_pkg: shared types and constants of the ordered pair set table
// holds the table size, opcodes, and the command and status structs
// between the controller and the datapath; depends on nothing
package opst_pkg;

	// table size and derived widths
	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 6;
	localparam int TAB_W    = 8;
	localparam int ITEM_W   = 16;
	localparam int POS_W    = 8;
	localparam int ENTRY_W  = TAB_W + ITEM_W;

	// opcodes of an input item
	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_LOOKUP = 3'd1,
		OP_TOGGLE = 3'd2,
		OP_ADD    = 3'd3,
		OP_RM_KEY = 3'd4,
		OP_RM_POS = 3'd5,
		OP_RD_POS = 3'd6,
		OP_APPEND = 3'd7
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic take;        // latch key and position of the accepted item
		logic clr;         // empty the table
		logic app;         // write key at the count and bump the count
		logic dec;         // drop the count by one
		logic scan_start;  // pointer to zero for a key search
		logic load_hit;    // pointer to the entry after the match
		logic load_pos;    // pointer to the entry after the position
		logic step;        // issue the next read at the pointer
		logic shift_mode;  // each returned entry is written one place down
		logic rd_pos;      // read the entry at the position
		logic res_load;    // fill the result register
		logic res_ok;      // success flag of the result
		logic res_rd;      // result carries the read entry
	} opst_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;         // returned entry matches the key
		logic miss;        // search went past the last entry
		logic shift_done;  // compaction finished
		logic full;        // count equals the capacity
		logic pos_ok;      // position is below the count
		logic res_free;    // result register can take a new result
	} opst_sts_t;

endpackage

>>> rtl/core/opst_ram.sv
// opst_ram: generic single write, single read memory with registered read
// read data holds while no read is issued; no dependencies
module opst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/opst_dp.sv
// opst_dp: datapath of the ordered pair set table
// entry memory, count, scan pointer, key compare and result register
// depends on opst_pkg and opst_ram
module opst_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  opst_pkg::opst_cmd_t         cmd,
	output opst_pkg::opst_sts_t         sts,
	input  logic [opst_pkg::TAB_W-1:0]  key_tab,
	input  logic [opst_pkg::ITEM_W-1:0] key_item,
	input  logic [opst_pkg::POS_W-1:0]  position,
	input  logic                        res_ready,
	output logic                        res_valid,
	output logic                        success,
	output logic [opst_pkg::TAB_W-1:0]  out_tab,
	output logic [opst_pkg::ITEM_W-1:0] out_item,
	output logic                        out_valid,
	output logic [opst_pkg::CNT_W-1:0]  total
);

	logic [opst_pkg::TAB_W-1:0]   tab_q;
	logic [opst_pkg::ITEM_W-1:0]  item_q;
	logic [opst_pkg::POS_W-1:0]   pos_q;
	logic [opst_pkg::CNT_W-1:0]   cnt_q;
	logic [opst_pkg::CNT_W-1:0]   ptr_q;
	logic                         rd_v_s1;
	logic [opst_pkg::IDX_W-1:0]   rd_idx_s1;
	logic                         issue;
	logic                         ram_we;
	logic [opst_pkg::IDX_W-1:0]   ram_waddr;
	logic [opst_pkg::ENTRY_W-1:0] ram_wdata;
	logic                         ram_re;
	logic [opst_pkg::IDX_W-1:0]   ram_raddr;
	logic [opst_pkg::ENTRY_W-1:0] ram_rdata;
	logic                         res_full_q;
	logic                         ok_q;
	logic [opst_pkg::TAB_W-1:0]   otab_q;
	logic [opst_pkg::ITEM_W-1:0]  oitem_q;
	logic                         ovalid_q;
	logic [opst_pkg::CNT_W-1:0]   total_q;

	// key and position of the item in work
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			tab_q  <= key_tab;
			item_q <= key_item;
			pos_q  <= position;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clr) begin
			cnt_q <= '0;
		end else if (cmd.app) begin
			cnt_q <= cnt_q + opst_pkg::CNT_W'(1);
		end else if (cmd.dec) begin
			cnt_q <= cnt_q - opst_pkg::CNT_W'(1);
		end
	end

	// scan pointer and read pipeline
	assign issue = cmd.step && (ptr_q < cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else if (cmd.scan_start) begin
			ptr_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else if (cmd.load_hit) begin
			ptr_q   <= opst_pkg::CNT_W'(rd_idx_s1) + opst_pkg::CNT_W'(1);
			rd_v_s1 <= 1'b0;
		end else if (cmd.load_pos) begin
			ptr_q   <= opst_pkg::CNT_W'(pos_q) + opst_pkg::CNT_W'(1);
			rd_v_s1 <= 1'b0;
		end else begin
			if (issue) begin
				ptr_q <= ptr_q + opst_pkg::CNT_W'(1);
			end
			rd_v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_idx_s1 <= ptr_q[opst_pkg::IDX_W-1:0];
		end
	end

	// memory ports: append or compaction write, pointer or position read
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[opst_pkg::IDX_W-1:0];
		ram_wdata = {tab_q, item_q};
		if (cmd.app) begin
			ram_we = 1'b1;
		end else if (cmd.shift_mode && rd_v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = rd_idx_s1 - opst_pkg::IDX_W'(1);
			ram_wdata = ram_rdata;
		end
	end

	assign ram_re    = issue || cmd.rd_pos;
	assign ram_raddr = cmd.rd_pos ? pos_q[opst_pkg::IDX_W-1:0] : ptr_q[opst_pkg::IDX_W-1:0];

	opst_ram #(
		.WIDTH(opst_pkg::ENTRY_W),
		.DEPTH(opst_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// status back to the controller
	always_comb begin
		sts.hit        = rd_v_s1 && (ram_rdata == {tab_q, item_q});
		sts.miss       = (ptr_q >= cnt_q) && !sts.hit;
		sts.shift_done = (ptr_q >= cnt_q) && !rd_v_s1;
		sts.full       = (cnt_q == opst_pkg::CNT_W'(opst_pkg::CAPACITY));
		sts.pos_ok     = (pos_q < opst_pkg::POS_W'(cnt_q));
		sts.res_free   = !res_full_q || res_ready;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_full_q <= 1'b0;
		end else if (cmd.res_load) begin
			res_full_q <= 1'b1;
		end else if (res_ready) begin
			res_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			ok_q     <= cmd.res_ok;
			otab_q   <= cmd.res_rd ? ram_rdata[opst_pkg::ENTRY_W-1:opst_pkg::ITEM_W] : '0;
			oitem_q  <= cmd.res_rd ? ram_rdata[opst_pkg::ITEM_W-1:0] : '0;
			ovalid_q <= cmd.res_rd;
			total_q  <= cnt_q;
		end
	end

	assign res_valid = res_full_q;
	assign success   = ok_q;
	assign out_tab   = otab_q;
	assign out_item  = oitem_q;
	assign out_valid = ovalid_q;
	assign total     = total_q;

	// count stays within the table
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= opst_pkg::CNT_W'(opst_pkg::CAPACITY))
		else $error("entry count above capacity");

	// no append into a full table
	a_app_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.app |-> !sts.full)
		else $error("append into a full table");

	// no removal from an empty table
	a_dec_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec |-> (cnt_q != '0))
		else $error("removal from an empty table");

	// a new result never overwrites one still waiting
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!res_full_q || res_ready))
		else $error("result overwritten before delivery");

endmodule

>>> rtl/core/opst_ctrl.sv
// opst_ctrl: controller state machine of the ordered pair set table
// decodes the opcode and sequences search, compaction and result
// depends on opst_pkg
module opst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          op,
	input  opst_pkg::opst_sts_t sts,
	output opst_pkg::opst_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_SHIFT = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	opst_pkg::op_t    op_q;
	logic             ok_q, ok_d;
	logic             rd_q, rd_d;

	// opcode of the item in work
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= opst_pkg::op_t'(op);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ok_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
			rd_q    <= rd_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		ok_d    = ok_q;
		rd_d    = rd_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					ok_d     = 1'b0;
					rd_d     = 1'b0;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q)
					opst_pkg::OP_CLEAR: begin
						cmd.clr = 1'b1;
						ok_d    = 1'b1;
						state_d = ST_FIN;
					end
					opst_pkg::OP_LOOKUP, opst_pkg::OP_TOGGLE, opst_pkg::OP_ADD,
					opst_pkg::OP_RM_KEY: begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
					opst_pkg::OP_RM_POS: begin
						if (sts.pos_ok) begin
							cmd.load_pos = 1'b1;
							ok_d         = 1'b1;
							state_d      = ST_SHIFT;
						end else begin
							state_d = ST_FIN;
						end
					end
					opst_pkg::OP_RD_POS: begin
						if (sts.pos_ok) begin
							cmd.rd_pos = 1'b1;
							ok_d       = 1'b1;
							rd_d       = 1'b1;
						end
						state_d = ST_FIN;
					end
					opst_pkg::OP_APPEND: begin
						if (!sts.full) begin
							cmd.app = 1'b1;
							ok_d    = 1'b1;
						end
						state_d = ST_FIN;
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end
			// key search, one entry per cycle
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.hit) begin
					case (op_q)
						opst_pkg::OP_LOOKUP: begin
							ok_d    = 1'b1;
							state_d = ST_FIN;
						end
						opst_pkg::OP_TOGGLE: begin
							cmd.load_hit = 1'b1;
							state_d      = ST_SHIFT;
						end
						opst_pkg::OP_RM_KEY: begin
							cmd.load_hit = 1'b1;
							ok_d         = 1'b1;
							state_d      = ST_SHIFT;
						end
						default: begin
							state_d = ST_FIN;
						end
					endcase
				end else if (sts.miss) begin
					// toggle and add append an absent pair when there is room
					if ((op_q == opst_pkg::OP_TOGGLE || op_q == opst_pkg::OP_ADD) &&
						!sts.full) begin
						cmd.app = 1'b1;
						ok_d    = 1'b1;
					end
					state_d = ST_FIN;
				end
			end
			// compaction, later entries move down one place
			ST_SHIFT: begin
				cmd.step       = 1'b1;
				cmd.shift_mode = 1'b1;
				if (sts.shift_done) begin
					cmd.dec = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.res_free) begin
					cmd.res_load = 1'b1;
					cmd.res_ok   = ok_q;
					cmd.res_rd   = rd_q;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// a search only runs for the key operations
	a_scan_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (op_q == opst_pkg::OP_LOOKUP ||
			op_q == opst_pkg::OP_TOGGLE || op_q == opst_pkg::OP_ADD ||
			op_q == opst_pkg::OP_RM_KEY))
		else $error("search started for a non-key operation");

	// every result load returns the machine to idle
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> (state_q == ST_IDLE))
		else $error("result loaded without returning to idle");

	// an item is taken only when idle
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> (state_q == ST_IDLE) && in_valid)
		else $error("item taken outside idle");

endmodule

>>> rtl/core/ordered_pair_set_table.sv
// ordered_pair_set_table: top level of the ordered pair set table
// joins the controller and the datapath; depends on opst_pkg, opst_ctrl, opst_dp
//
// Keeps up to 32 (tab, item) pairs in insertion order and applies one operation per
// item: clear, lookup, toggle, add, remove by key, remove by position, read by position
// or unchecked append; every item returns one result with success, the entry read and
// the count after the operation. One item is in work at a time and the result sits in
// an output register, so the next item is taken while a result still waits; that item's
// own result then holds the controller until the register is free. A key search stops
// at the first matching entry or after the last stored entry; a removal then compacts
// the table, moving every later entry down one place. The single read port of the
// entry memory reads one entry per cycle during search and compaction.
module ordered_pair_set_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [7:0]  key_tab,
	input  logic [15:0] key_item,
	input  logic [7:0]  position,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        success,
	output logic [7:0]  out_tab,
	output logic [15:0] out_item,
	output logic        out_valid,
	output logic [5:0]  total
);

	opst_pkg::opst_cmd_t cmd;
	opst_pkg::opst_sts_t sts;

	// sequencing
	opst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op      (op),
		.sts     (sts),
		.cmd     (cmd)
	);

	// storage, compare and result
	opst_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.key_tab  (key_tab),
		.key_item (key_item),
		.position (position),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.success  (success),
		.out_tab  (out_tab),
		.out_item (out_item),
		.out_valid(out_valid),
		.total    (total)
	);

endmodule
